[hw/rtl/s2i64_pkg.sv]
package s2i64_pkg;

    localparam int BASE_W  = 6;
    localparam int CH_W    = 8;
    localparam int VAL_W   = 64;
    localparam int DIGIT_W = 6;
    localparam int END_W   = 12;

    // configuration register indexes
    localparam logic CFG_NUMBER_BASE   = 1'b0;
    localparam logic CFG_UNSIGNED_MODE = 1'b1;

    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_ONE  = 6'd1;
    localparam logic [BASE_W-1:0] BASE_TWO  = 6'd2;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;

    localparam logic [DIGIT_W-1:0] DIGIT_NONE = 6'd63;

    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CH_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [CH_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CH_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CH_W-1:0] CH_LO_X  = 8'h78;
    localparam logic [CH_W-1:0] CH_LO_Z  = 8'h7A;

    typedef struct packed {
        logic             is_digit;
        logic             overflow;
        logic [VAL_W-1:0] acc_next;
    } t_mac_res;

    function automatic logic is_space(input logic [CH_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic [DIGIT_W-1:0] digit_val(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] t;
        t = DIGIT_NONE;
        if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
            t = c - CH_ZERO;
        end else if ((c >= CH_UP_A) && (c <= CH_UP_Z)) begin
            t = c - CH_UP_A + 8'd10;
        end else if ((c >= CH_LO_A) && (c <= CH_LO_Z)) begin
            t = c - CH_LO_A + 8'd10;
        end
        return t[DIGIT_W-1:0];
    endfunction

endpackage

[hw/rtl/s2i64_mac.sv]
module s2i64_mac (
    input  logic [s2i64_pkg::VAL_W-1:0]  i_acc,
    input  logic [s2i64_pkg::BASE_W-1:0] i_base,
    input  logic [s2i64_pkg::CH_W-1:0]   i_ch,
    output s2i64_pkg::t_mac_res          o_res
);
    import s2i64_pkg::*;

    localparam int PROD_W = VAL_W + BASE_W;

    logic [BASE_W-1:0]  base;
    logic [DIGIT_W-1:0] dig;
    logic [PROD_W-1:0]  sum;

    always_comb begin
        base = i_base;
        if ((i_base < BASE_TWO) || (i_base > BASE_MAX)) begin
            base = BASE_DEC;
        end
    end

    assign dig = digit_val(i_ch);

    // acc * base + digit beyond 64 bits is the overflow condition
    assign sum = PROD_W'(i_acc) * PROD_W'(base) + PROD_W'(dig);

    assign o_res.is_digit = (dig < base);
    assign o_res.overflow = |sum[PROD_W-1:VAL_W];
    assign o_res.acc_next = sum[VAL_W-1:0];

endmodule

[hw/rtl/s2i64_result.sv]
module s2i64_result #(
    parameter int POS_W = 12
) (
    input  logic [s2i64_pkg::VAL_W-1:0] i_acc,
    input  logic                        i_negative,
    input  logic                        i_overflow_seen,
    input  logic                        i_digit_seen,
    input  logic                        i_unsigned_mode,
    input  logic [POS_W-1:0]            i_stop_pos,
    output logic [s2i64_pkg::VAL_W-1:0] o_value,
    output logic [s2i64_pkg::END_W-1:0] o_end_index,
    output logic                        o_converted,
    output logic                        o_overflowed
);
    import s2i64_pkg::*;

    localparam logic [VAL_W-1:0] INT_MIN_BITS = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [VAL_W-1:0] INT_MAX_BITS = {1'b0, {(VAL_W-1){1'b1}}};

    logic [VAL_W-1:0] limit;
    logic             ovf;

    always_comb begin
        limit = i_negative ? INT_MIN_BITS : INT_MAX_BITS;
        ovf   = i_overflow_seen || (!i_unsigned_mode && (i_acc > limit));

        o_value      = '0;
        o_end_index  = '0;
        o_overflowed = 1'b0;
        if (i_digit_seen) begin
            o_end_index  = END_W'(i_stop_pos);
            o_overflowed = ovf;
            if (ovf) begin
                if (i_unsigned_mode) begin
                    o_value = '1;
                end else begin
                    o_value = limit;
                end
            end else begin
                o_value = i_negative ? (VAL_W'(0) - i_acc) : i_acc;
            end
        end
        o_converted = i_digit_seen;
    end

endmodule

[hw/rtl/string_to_int64_parser.sv]
// Streaming strtoll/strtoull parser. Characters of a NUL-terminated string enter one per
// cycle on i_ch; leading white space, an optional sign and an optional 0x prefix are taken,
// then digits of the selected radix (2..36, 0 auto-detects 8/10/16) are accumulated with
// 64-bit overflow detection. Bytes after the number are ignored. The NUL produces exactly one
// result: the value (saturated in signed or unsigned mode), the index of the first
// unconverted character, and converted/overflow flags; the parser then rearms for the next
// string. Throughput is one character per cycle while i_ch is not stalled; a result is
// offered once its NUL passes the input register and the one parse stage that loads the
// result register; the 64x6 multiply-accumulate into the accumulator sets the clock period.
// A NUL stalls i_ch in the input register while an earlier result is still held on the output.
// number_base is sampled at the first non-blank character of each string; write
// configuration only while no string is in flight.
module string_to_int64_parser #(
    parameter int MAX_LEN = 4095
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [s2i64_pkg::BASE_W-1:0]  i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [s2i64_pkg::CH_W-1:0]    i_ch,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [s2i64_pkg::VAL_W-1:0]   o_result_value,
    output logic [s2i64_pkg::END_W-1:0]   o_end_index,
    output logic                          o_converted,
    output logic                          o_overflowed
);
    import s2i64_pkg::*;

    localparam int POS_W = $clog2(MAX_LEN + 1);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_LEN);

    localparam logic [2:0] PH_SKIP   = 3'd0;
    localparam logic [2:0] PH_SIGNED = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_PREFIX = 3'd3;
    localparam logic [2:0] PH_DIGITS = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    // configuration
    logic [BASE_W-1:0] r_number_base;
    logic              r_unsigned_mode;

    // input register
    logic              r_in_valid;
    logic [CH_W-1:0]   r_in_ch;

    // parse state
    logic [2:0]        r_phase, n_phase;
    logic              r_negative, n_negative;
    logic [VAL_W-1:0]  r_acc, n_acc;
    logic              r_ovf_seen, n_ovf_seen;
    logic [BASE_W-1:0] r_eff_base, n_eff_base;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [POS_W-1:0]  r_stop_pos, n_stop_pos;
    logic              r_digit_seen, n_digit_seen;

    // result register
    logic              r_out_valid;
    logic [VAL_W-1:0]  r_res_value;
    logic [END_W-1:0]  r_res_end;
    logic              r_res_conv;
    logic              r_res_ovf;

    logic              is_nul;
    logic              out_free;
    logic              step;
    logic              load_out;
    logic [POS_W-1:0]  pos_adv;
    logic [BASE_W-1:0] cfg_base;
    logic [BASE_W-1:0] td_base;
    t_mac_res          mac;
    logic [VAL_W-1:0]  fin_value;
    logic [END_W-1:0]  fin_end;
    logic              fin_conv;
    logic              fin_ovf;

    assign is_nul   = (r_in_ch == CH_NUL);
    assign out_free = !r_out_valid || i_ready;
    assign step     = r_in_valid && (!is_nul || out_free);
    assign load_out = step && is_nul;
    assign o_ready  = !r_in_valid || step;

    assign pos_adv = (r_pos < POS_LIMIT) ? (r_pos + POS_W'(1)) : r_pos;

    always_comb begin
        cfg_base = r_number_base;
        if ((r_number_base == BASE_ONE) || (r_number_base > BASE_MAX)) begin
            cfg_base = BASE_DEC;
        end
    end

    // radix the digit unit sees in the current phase
    always_comb begin
        unique case (r_phase)
            PH_SKIP:   td_base = (cfg_base == BASE_AUTO) ? BASE_DEC : cfg_base;
            PH_SIGNED: td_base = (r_eff_base == BASE_AUTO) ? BASE_DEC : r_eff_base;
            PH_ZERO:   td_base = (r_eff_base == BASE_AUTO) ? BASE_OCT : r_eff_base;
            default:   td_base = r_eff_base;
        endcase
    end

    s2i64_mac u_mac (
        .i_acc  (r_acc),
        .i_base (td_base),
        .i_ch   (r_in_ch),
        .o_res  (mac)
    );

    s2i64_result #(
        .POS_W (POS_W)
    ) u_result (
        .i_acc           (r_acc),
        .i_negative      (r_negative),
        .i_overflow_seen (r_ovf_seen),
        .i_digit_seen    (r_digit_seen),
        .i_unsigned_mode (r_unsigned_mode),
        .i_stop_pos      (r_stop_pos),
        .o_value         (fin_value),
        .o_end_index     (fin_end),
        .o_converted     (fin_conv),
        .o_overflowed    (fin_ovf)
    );

    always_comb begin
        logic do_digit;
        logic zero_lead;
        do_digit  = 1'b0;
        zero_lead = 1'b0;

        n_phase      = r_phase;
        n_negative   = r_negative;
        n_acc        = r_acc;
        n_ovf_seen   = r_ovf_seen;
        n_eff_base   = r_eff_base;
        n_pos        = r_pos;
        n_stop_pos   = r_stop_pos;
        n_digit_seen = r_digit_seen;

        if (step) begin
            if (is_nul) begin
                n_phase      = PH_SKIP;
                n_negative   = 1'b0;
                n_acc        = '0;
                n_ovf_seen   = 1'b0;
                n_eff_base   = BASE_DEC;
                n_pos        = '0;
                n_stop_pos   = '0;
                n_digit_seen = 1'b0;
            end else begin
                unique case (r_phase) inside
                    PH_SKIP: begin
                        if (is_space(r_in_ch)) begin
                            n_pos = pos_adv;
                        end else if ((r_in_ch == CH_MINUS) || (r_in_ch == CH_PLUS)) begin
                            n_eff_base = cfg_base;
                            n_negative = (r_in_ch == CH_MINUS);
                            n_pos      = pos_adv;
                            n_phase    = PH_SIGNED;
                        end else begin
                            n_eff_base = cfg_base;
                            zero_lead  = (r_in_ch == CH_ZERO) &&
                                         ((cfg_base == BASE_AUTO) || (cfg_base == BASE_HEX));
                            do_digit   = !zero_lead;
                            if (!zero_lead) begin
                                n_eff_base = td_base;
                            end
                        end
                    end
                    PH_SIGNED: begin
                        zero_lead = (r_in_ch == CH_ZERO) &&
                                    ((r_eff_base == BASE_AUTO) || (r_eff_base == BASE_HEX));
                        do_digit  = !zero_lead;
                        if (!zero_lead) begin
                            n_eff_base = td_base;
                        end
                    end
                    PH_ZERO: begin
                        if ((r_in_ch == CH_LO_X) || (r_in_ch == CH_UP_X)) begin
                            n_eff_base = BASE_HEX;
                            n_pos      = pos_adv;
                            n_phase    = PH_PREFIX;
                        end else begin
                            n_eff_base = td_base;
                            do_digit   = 1'b1;
                        end
                    end
                    PH_PREFIX, PH_DIGITS: begin
                        do_digit = 1'b1;
                    end
                    default: begin
                        n_phase = PH_DONE;
                    end
                endcase

                // leading zero in base 0 or 16 counts as a digit
                if (zero_lead) begin
                    n_acc        = '0;
                    n_digit_seen = 1'b1;
                    n_pos        = pos_adv;
                    n_stop_pos   = pos_adv;
                    n_phase      = PH_ZERO;
                end

                if (do_digit) begin
                    if (!mac.is_digit) begin
                        n_phase = PH_DONE;
                    end else begin
                        if (mac.overflow) begin
                            n_ovf_seen = 1'b1;
                        end else begin
                            n_acc = mac.acc_next;
                        end
                        n_pos        = pos_adv;
                        n_stop_pos   = pos_adv;
                        n_digit_seen = 1'b1;
                        n_phase      = PH_DIGITS;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base   <= BASE_DEC;
            r_unsigned_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NUMBER_BASE:   r_number_base   <= i_cfg_data;
                CFG_UNSIGNED_MODE: r_unsigned_mode <= i_cfg_data[0];
                default:           r_number_base   <= r_number_base;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_ch <= i_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SKIP;
            r_negative   <= 1'b0;
            r_acc        <= '0;
            r_ovf_seen   <= 1'b0;
            r_eff_base   <= BASE_DEC;
            r_pos        <= '0;
            r_stop_pos   <= '0;
            r_digit_seen <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_negative   <= n_negative;
            r_acc        <= n_acc;
            r_ovf_seen   <= n_ovf_seen;
            r_eff_base   <= n_eff_base;
            r_pos        <= n_pos;
            r_stop_pos   <= n_stop_pos;
            r_digit_seen <= n_digit_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_res_value <= fin_value;
            r_res_end   <= fin_end;
            r_res_conv  <= fin_conv;
            r_res_ovf   <= fin_ovf;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_value = r_res_value;
    assign o_end_index    = r_res_end;
    assign o_converted    = r_res_conv;
    assign o_overflowed   = r_res_ovf;

`ifndef SYNTHESIS
    a_rearm_after_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (r_phase == PH_SKIP) && !r_digit_seen && (r_pos == '0))
        else $error("parser not rearmed after terminating item");

    a_acc_needs_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_digit_seen |-> (r_acc == '0) && !r_ovf_seen)
        else $error("accumulator changed before any digit");

    a_stop_le_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stop_pos <= r_pos)
        else $error("stop position ahead of position");

    a_ovf_implies_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res_ovf |-> r_res_conv)
        else $error("overflow flagged without conversion");
`endif

endmodule
